FILE: src/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request line parser package
// Beat types, status codes, method codes and the method name tables shared
// by the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  // Default widths and limits for the parser parameters.
  localparam int unsigned DefOffsetBits     = 16;
  localparam int unsigned DefMinBufferBytes = 16;

  // Result status codes.
  localparam logic [2:0] StatusOk         = 3'd0;
  localparam logic [2:0] StatusTooShort   = 3'd1;
  localparam logic [2:0] StatusBadMethod  = 3'd2;
  localparam logic [2:0] StatusBadUri     = 3'd3;
  localparam logic [2:0] StatusBadVersion = 3'd4;
  localparam logic [2:0] StatusIncomplete = 3'd5;

  // Method codes of interest; zero means unrecognised.
  localparam logic [3:0] MethodNone = 4'd0;
  localparam logic [3:0] MethodGet  = 4'd1;

  // Positions within the version text "HTTP/d.d".
  localparam logic [2:0] VerPosMajor = 3'd5;
  localparam logic [2:0] VerPosDot   = 3'd6;
  localparam logic [2:0] VerPosMinor = 3'd7;

  // Character codes.
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam int unsigned NumNames    = 15;
  localparam int unsigned MaxNameLen  = 9;
  localparam logic [3:0]  MinTokenLen = 4'd3;

  // Method names, right-justified: the last character sits in the low byte.
  localparam logic [8*MaxNameLen-1:0] NameText [NumNames] = '{
    72'("GET"), 72'("PUT"), 72'("POST"), 72'("COPY"), 72'("MOVE"),
    72'("LOCK"), 72'("HEAD"), 72'("MKCOL"), 72'("PATCH"), 72'("TRACE"),
    72'("DELETE"), 72'("UNLOCK"), 72'("OPTIONS"), 72'("PROPFIND"),
    72'("PROPPATCH")
  };

  localparam logic [3:0] NameLen [NumNames] = '{
    4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd8, 4'd9
  };

  // Leading part of the version text, first character in the high byte.
  localparam logic [39:0] VersionLead = "HTTP/";

  // Input beat: one byte of the request buffer.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] buffer_length;
  } in_beat_t;

  // Output beat: one parse result.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  method_code;
    logic [6:0]  version_number;
    logic [15:0] uri_offset;
    logic [15:0] uri_length;
    logic [15:0] bytes_consumed;
  } out_beat_t;

  // Parse phases, one-hot.
  typedef enum logic [4:0] {
    PhIdle    = 5'b00001,
    PhMethod  = 5'b00010,
    PhUri     = 5'b00100,
    PhVersion = 5'b01000,
    PhDone    = 5'b10000
  } phase_e;

endpackage

FILE: src/http_request_line_parser_unit.sv
// ----------------------------------------------------------------------------
// HTTP request line parser
// Parses "METHOD SP URI SP HTTP/d.d" from a byte stream and issues one result
// beat per buffer: status, method code, version, URI position and length.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Beat
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | in_valid_i/in_stall_o | one buffer byte
//  out     | output    | out_valid_o/out_stall_i | one parse result
//
// A byte is taken into an input register, parsed from there against the parser
// state once the output register can take a result, and any result is written
// to the output register. One byte is accepted per cycle while not stalled;
// names match incrementally. The input stalls only while a result waits, stalled,
// in the output register and a byte is held in the input register.
// Reset returns the parser to idle, waiting for a first byte.
module http_request_line_parser_unit #(
  parameter int unsigned OffsetBits     = hrlp_pkg::DefOffsetBits,
  parameter int unsigned MinBufferBytes = hrlp_pkg::DefMinBufferBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hrlp_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hrlp_pkg::out_beat_t out_data_o
);
  import hrlp_pkg::*;

  localparam int unsigned CmpBits = (OffsetBits > 16) ? OffsetBits : 16;

  // Input register.
  logic     s1_valid_q;
  in_beat_t s1_data_q;

  // Output register.
  logic      out_valid_q;
  out_beat_t out_data_q;

  // Parser state.
  phase_e                phase_q, phase_d;
  logic [OffsetBits-1:0] byte_idx_q, byte_idx_d;
  logic [15:0]           exp_len_q, exp_len_d;
  logic [3:0]            tok_len_q, tok_len_d;
  logic [NumNames-1:0]   cand_q, cand_d;
  logic [OffsetBits-1:0] uri_start_q, uri_start_d;
  logic [OffsetBits-1:0] uri_len_q, uri_len_d;
  logic [2:0]            ver_pos_q, ver_pos_d;
  logic [3:0]            major_q, major_d;
  logic [3:0]            minor_q, minor_d;
  logic [3:0]            method_q, method_d;

  // Result of parsing the registered byte.
  logic       emit;
  logic [2:0] res_status;
  logic       res_with_ver;
  logic       res_with_cons;
  logic       out_free;
  logic       advance;

  // Handshake: parse when the output register can take a result.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  // Parse one byte against the current state.
  always_comb begin
    logic [7:0]            c;
    logic [OffsetBits-1:0] idx;
    logic [6:0]            name_base;
    logic [5:0]            lead_base;
    logic                  good;
    logic                  process;

    c         = s1_data_q.data_byte;
    phase_d   = phase_q;
    byte_idx_d = byte_idx_q;
    exp_len_d = exp_len_q;
    tok_len_d = tok_len_q;
    cand_d    = cand_q;
    uri_start_d = uri_start_q;
    uri_len_d = uri_len_q;
    ver_pos_d = ver_pos_q;
    major_d   = major_q;
    minor_d   = minor_q;
    method_d  = method_q;
    emit          = 1'b0;
    res_status    = StatusOk;
    res_with_ver  = 1'b0;
    res_with_cons = 1'b0;
    process   = 1'b1;
    good      = 1'b0;
    name_base = '0;
    lead_base = '0;

    // A first byte restarts the parse from a clean state.
    if (s1_data_q.first_byte) begin
      phase_d     = PhMethod;
      byte_idx_d  = '0;
      exp_len_d   = s1_data_q.buffer_length;
      tok_len_d   = '0;
      cand_d      = '1;
      uri_start_d = '0;
      uri_len_d   = '0;
      ver_pos_d   = '0;
      major_d     = '0;
      minor_d     = '0;
      method_d    = MethodNone;
      if (s1_data_q.buffer_length < 16'(MinBufferBytes)) begin
        emit       = 1'b1;
        res_status = StatusTooShort;
        process    = 1'b0;
      end
    end else if (phase_q == PhIdle || phase_q == PhDone) begin
      process = 1'b0;
    end

    idx = byte_idx_d;

    if (process) begin
      unique case (phase_d)
        PhMethod: begin
          if (c == CharSpace) begin
            if (tok_len_d < MinTokenLen) begin
              emit       = 1'b1;
              res_status = StatusBadMethod;
            end else begin
              for (int k = 0; k < NumNames; k++) begin
                if (cand_d[k] && NameLen[k] == tok_len_d) begin
                  method_d = 4'(k + 1);
                end
              end
              uri_start_d = idx + OffsetBits'(1);
              phase_d     = PhUri;
            end
          end else if (c == CharNul || tok_len_d >= 4'(MaxNameLen)) begin
            emit       = 1'b1;
            res_status = StatusBadMethod;
          end else begin
            // Drop every name that is too short or differs at this position.
            for (int k = 0; k < NumNames; k++) begin
              name_base = {4'(NameLen[k] - 4'd1 - tok_len_d), 3'b000};
              if (NameLen[k] <= tok_len_d || NameText[k][name_base +: 8] != c) begin
                cand_d[k] = 1'b0;
              end
            end
            tok_len_d = tok_len_d + 4'd1;
          end
        end
        PhUri: begin
          if (c == CharSpace) begin
            if (idx == uri_start_d) begin
              emit       = 1'b1;
              res_status = StatusBadUri;
            end else begin
              uri_len_d = idx - uri_start_d;
              ver_pos_d = '0;
              phase_d   = PhVersion;
            end
          end else if (c == CharNul) begin
            emit       = 1'b1;
            res_status = StatusBadUri;
          end
        end
        PhVersion: begin
          lead_base = {3'(3'd4 - ver_pos_d), 3'b000};
          if (ver_pos_d < VerPosMajor) begin
            good = (c == VersionLead[lead_base +: 8]);
          end else if (ver_pos_d == VerPosDot) begin
            good = (c == CharDot);
          end else begin
            good = (c >= CharZero) && (c <= CharNine);
          end
          if (!good) begin
            emit       = 1'b1;
            res_status = StatusBadVersion;
          end else if (ver_pos_d == VerPosMinor) begin
            minor_d      = c[3:0];
            emit         = 1'b1;
            res_with_ver = 1'b1;
            if (major_d == 4'd0 && c[3:0] == 4'd9 && method_d != MethodGet) begin
              res_status = StatusBadMethod;
            end else begin
              res_status    = StatusOk;
              res_with_cons = 1'b1;
            end
          end else begin
            if (ver_pos_d == VerPosMajor) begin
              major_d = c[3:0];
            end
            ver_pos_d = ver_pos_d + 3'd1;
          end
        end
        default: begin
          process = 1'b0;
        end
      endcase

      // Running out of bytes before an outcome leaves the request incomplete.
      if (!emit && process) begin
        byte_idx_d = idx + OffsetBits'(1);
        if (s1_data_q.last_byte || CmpBits'(byte_idx_d) >= CmpBits'(exp_len_d)) begin
          emit       = 1'b1;
          res_status = StatusIncomplete;
        end
      end
    end

    if (emit) begin
      phase_d = PhDone;
    end
  end

  // Input register: a byte is taken whenever the register is empty or moving.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      byte_idx_q  <= '0;
      exp_len_q   <= '0;
      tok_len_q   <= '0;
      cand_q      <= '1;
      uri_start_q <= '0;
      uri_len_q   <= '0;
      ver_pos_q   <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      method_q    <= MethodNone;
    end else if (advance) begin
      phase_q     <= phase_d;
      byte_idx_q  <= byte_idx_d;
      exp_len_q   <= exp_len_d;
      tok_len_q   <= tok_len_d;
      cand_q      <= cand_d;
      uri_start_q <= uri_start_d;
      uri_len_q   <= uri_len_d;
      ver_pos_q   <= ver_pos_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      method_q    <= method_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_data_q.status         <= res_status;
      out_data_q.method_code    <= method_d;
      out_data_q.version_number <= res_with_ver ?
                                   (7'(major_d) * 7'd10 + 7'(minor_d)) : 7'd0;
      out_data_q.uri_offset     <= (uri_len_d != '0) ? 16'(uri_start_d) : 16'd0;
      out_data_q.uri_length     <= 16'(uri_len_d);
      out_data_q.bytes_consumed <= res_with_cons ?
                                   16'(byte_idx_d + OffsetBits'(3)) : 16'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
